// ===== sv/utf8_to_utf16_transcoder_top_assert.svh =====
// Assertion macros for the UTF-8 to UTF-16 transcoder.
// Included by the top level; simulation builds get checks, synthesis gets nothing.
`ifndef UTF8_TO_UTF16_TRANSCODER_TOP_ASSERT_SVH
`define UTF8_TO_UTF16_TRANSCODER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// check a property while out of reset
`define U8U16_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// check a property at every edge, reset included
`define U8U16_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define U8U16_ASSERT(lbl, clk, rstn, prop, msg)
`define U8U16_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== sv/u8u16_pkg.sv =====
// Shared types, constants and helper functions for the UTF-8 to UTF-16 transcoder.
// No dependencies; compiled first.
package u8u16_pkg;

  localparam int unsigned POS_BITS_DEF = 24;

  // error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_BAD_LEAD  = 3'd1;
  localparam logic [2:0] ERR_DANG2     = 3'd2;
  localparam logic [2:0] ERR_DANG3     = 3'd3;
  localparam logic [2:0] ERR_OVERLONG3 = 3'd4;
  localparam logic [2:0] ERR_DANG4     = 3'd5;
  localparam logic [2:0] ERR_RANGE4    = 3'd6;

  // record kinds
  localparam logic KIND_UNIT    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // configuration register indexes
  localparam logic CFG_SWAP = 1'b0;
  localparam logic CFG_BOM  = 1'b1;

  // code point limits
  localparam logic [20:0] CP_MAX      = 21'h10FFFF;
  localparam logic [20:0] CP_SUPP     = 21'h010000;
  localparam logic [20:0] CP_MIN3     = 21'h000800;
  localparam logic [20:0] CP_SURR_LO  = 21'h00D800;
  localparam logic [20:0] CP_SURR_HI  = 21'h00DFFF;
  localparam logic [15:0] HI_SURR     = 16'hD800;
  localparam logic [15:0] LO_SURR     = 16'hDC00;
  localparam logic [15:0] BOM_UNIT    = 16'hFEFF;
  localparam logic [7:0]  LEAD_MIN    = 8'hC2;
  localparam logic [7:0]  LEAD_LIMIT  = 8'hF5;
  localparam logic [7:0]  LEAD3_MIN   = 8'hE0;
  localparam logic [7:0]  LEAD4_MIN   = 8'hF0;

  typedef struct packed {
    logic swap;
    logic bom;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  code;
    logic [20:0] val;
  } fail_t;

  // results caused by one transaction: up to three units and a summary
  typedef struct packed {
    logic [3:0][15:0] units;
    logic [1:0]       n_units;
    logic             has_sum;
    logic [2:0]       err;
    logic [23:0]      err_off;
    logic [20:0]      bad;
    logic [23:0]      fna;
    logic [23:0]      cnt;
  } bundle_t;

  function automatic logic [15:0] swap16(logic [15:0] u, logic en);
    return en ? {u[7:0], u[15:8]} : u;
  endfunction

  // dangling-sequence error: recover the lead byte from the accumulator
  function automatic fail_t dangling(logic [2:0] len, logic [1:0] pend, logic [20:0] acc);
    logic [1:0]  k;
    logic [20:0] lead;
    fail_t       f;
    k = 2'(len - 3'd1 - {1'b0, pend});
    case (k)
      2'd0:    lead = acc;
      2'd1:    lead = acc >> 6;
      2'd2:    lead = acc >> 12;
      default: lead = acc >> 18;
    endcase
    case (len)
      3'd2: begin
        f.code = ERR_DANG2;
        f.val  = {13'd0, 3'b110, lead[4:0]};
      end
      3'd3: begin
        f.code = ERR_DANG3;
        f.val  = {13'd0, 4'b1110, lead[3:0]};
      end
      default: begin
        f.code = ERR_DANG4;
        f.val  = {13'd0, 5'b11110, lead[2:0]};
      end
    endcase
    return f;
  endfunction

endpackage

// ===== sv/u8u16_if.sv =====
// Valid/ready channel interfaces for the transcoder input bytes and output records.
// No dependencies.
interface u8u16_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       no_byte;
  logic       end_of_string;

  modport source (output valid, in_byte, no_byte, end_of_string, input ready);
  modport sink   (input valid, in_byte, no_byte, end_of_string, output ready);
endinterface

interface u8u16_out_if;
  logic        valid;
  logic        ready;
  logic        record_kind;
  logic [15:0] unit;
  logic [2:0]  error_code;
  logic [23:0] error_offset;
  logic [20:0] bad_value;
  logic [23:0] first_non_ascii;
  logic [23:0] unit_count;
  logic        last_of_run;

  modport source (output valid, record_kind, unit, error_code, error_offset, bad_value,
                  first_non_ascii, unit_count, last_of_run, input ready);
  modport sink   (input valid, record_kind, unit, error_code, error_offset, bad_value,
                  first_non_ascii, unit_count, last_of_run, output ready);
endinterface

// ===== sv/u8u16_decode.sv =====
// Per-byte UTF-8 decoder: string state registers and one-pass decode to a result bundle.
// Depends on u8u16_pkg.
module u8u16_decode #(
  parameter int unsigned POSITION_BITS = u8u16_pkg::POS_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  logic [7:0]          in_byte_i,
  input  logic                no_byte_i,
  input  logic                end_of_string_i,
  input  u8u16_pkg::cfg_t     cfg_i,
  output u8u16_pkg::bundle_t  bundle_o,
  output logic                bundle_valid_o
);
  import u8u16_pkg::*;

  localparam int unsigned PB = POSITION_BITS;
  localparam logic [PB-1:0] CNT_MAX = '1;

  logic [PB-1:0] pos_q, pos_d, lead_q, lead_d, fna_q, fna_d;
  logic [PB-1:0] units_q, units_d, epos_q, epos_d, cnt_inc;
  logic [1:0]    pend_q, pend_d;
  logic [2:0]    seqlen_q, seqlen_d;
  logic [20:0]   acc_q, acc_d, eval_q, eval_d, cp, v;
  logic          nas_q, nas_d, bom_q, bom_d;
  logic [2:0]    err_q, err_d;

  logic [1:0]    nu_cp;
  logic [15:0]   u0, u1;
  logic          bom_emit;
  fail_t         f_byte, f_end;
  bundle_t       b_d;

  assign cp      = {acc_q[14:0], in_byte_i[5:0]};
  assign v       = cp - CP_SUPP;
  assign f_byte  = dangling(seqlen_q, pend_q, acc_q);

  // decode one transaction
  always_comb begin
    pos_d    = pos_q;
    lead_d   = lead_q;
    fna_d    = fna_q;
    units_d  = units_q;
    epos_d   = epos_q;
    pend_d   = pend_q;
    seqlen_d = seqlen_q;
    acc_d    = acc_q;
    eval_d   = eval_q;
    nas_d    = nas_q;
    bom_d    = bom_q;
    err_d    = err_q;
    nu_cp    = 2'd0;
    u0       = '0;
    u1       = '0;
    cnt_inc  = '0;
    f_end    = '0;
    b_d      = '0;

    if (!no_byte_i) begin
      if (err_q == ERR_NONE) begin
        if (pend_q == 2'd0) begin
          if (!in_byte_i[7]) begin
            nu_cp = 2'd1;
            u0    = {8'd0, in_byte_i};
          end else begin
            if (!nas_q) begin
              nas_d = 1'b1;
              fna_d = pos_q;
            end
            if (in_byte_i < LEAD_MIN || in_byte_i >= LEAD_LIMIT) begin
              err_d  = ERR_BAD_LEAD;
              epos_d = pos_q;
              eval_d = {13'd0, in_byte_i};
              pend_d = 2'd0;
            end else begin
              lead_d = pos_q;
              if (in_byte_i < LEAD3_MIN) begin
                seqlen_d = 3'd2;
                acc_d    = {16'd0, in_byte_i[4:0]};
                pend_d   = 2'd1;
              end else if (in_byte_i < LEAD4_MIN) begin
                seqlen_d = 3'd3;
                acc_d    = {17'd0, in_byte_i[3:0]};
                pend_d   = 2'd2;
              end else begin
                seqlen_d = 3'd4;
                acc_d    = {18'd0, in_byte_i[2:0]};
                pend_d   = 2'd3;
              end
            end
          end
        end else if (in_byte_i[7:6] != 2'b10) begin
          // broken continuation
          err_d  = f_byte.code;
          epos_d = lead_q;
          eval_d = f_byte.val;
          pend_d = 2'd0;
        end else begin
          acc_d  = cp;
          pend_d = pend_q - 2'd1;
          if (pend_q == 2'd1) begin
            if (seqlen_q == 3'd3 &&
                (cp < CP_MIN3 || (cp >= CP_SURR_LO && cp <= CP_SURR_HI))) begin
              err_d  = ERR_OVERLONG3;
              epos_d = lead_q;
              eval_d = cp;
            end else if (seqlen_q == 3'd4 && (cp < CP_SUPP || cp > CP_MAX)) begin
              err_d  = ERR_RANGE4;
              epos_d = lead_q;
              eval_d = cp;
            end else if (cp < CP_SUPP) begin
              nu_cp = 2'd1;
              u0    = cp[15:0];
            end else begin
              nu_cp = 2'd2;
              u0    = HI_SURR + {6'd0, v[19:10]};
              u1    = LO_SURR + {6'd0, v[9:0]};
            end
          end
        end
      end
      if (pos_q != CNT_MAX) pos_d = pos_q + 1'b1;
    end

    // saturating unit count, up to two per transaction
    cnt_inc = (units_q != CNT_MAX) ? units_q + 1'b1 : units_q;
    if (nu_cp != 2'd0) units_d = cnt_inc;
    if (nu_cp == 2'd2 && cnt_inc != CNT_MAX) units_d = cnt_inc + 1'b1;

    // byte order mark before the first unit of a string
    bom_emit = cfg_i.bom && !bom_q && (nu_cp != 2'd0);
    if (bom_emit) bom_d = 1'b1;

    if (bom_emit) begin
      b_d.units[0] = swap16(BOM_UNIT, cfg_i.swap);
      b_d.units[1] = swap16(u0, cfg_i.swap);
      b_d.units[2] = swap16(u1, cfg_i.swap);
    end else begin
      b_d.units[0] = swap16(u0, cfg_i.swap);
      b_d.units[1] = swap16(u1, cfg_i.swap);
    end
    b_d.n_units = nu_cp + {1'b0, bom_emit};

    // end of string: close open sequence, build summary, clear state
    if (end_of_string_i) begin
      if (err_d == ERR_NONE && pend_d != 2'd0) begin
        f_end  = dangling(seqlen_d, pend_d, acc_d);
        err_d  = f_end.code;
        epos_d = lead_d;
        eval_d = f_end.val;
      end
      b_d.has_sum = 1'b1;
      b_d.err     = err_d;
      b_d.err_off = (err_d != ERR_NONE) ? 24'(epos_d) : 24'd0;
      b_d.bad     = (err_d != ERR_NONE) ? eval_d : 21'd0;
      b_d.fna     = nas_d ? 24'(fna_d) : 24'(pos_d);
      b_d.cnt     = 24'(units_d);
      pos_d    = '0;
      lead_d   = '0;
      fna_d    = '0;
      units_d  = '0;
      epos_d   = '0;
      pend_d   = 2'd0;
      seqlen_d = 3'd0;
      acc_d    = '0;
      eval_d   = '0;
      nas_d    = 1'b0;
      bom_d    = 1'b0;
      err_d    = ERR_NONE;
    end
  end

  assign bundle_o       = b_d;
  assign bundle_valid_o = (b_d.n_units != 2'd0) || b_d.has_sum;

  // string state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      lead_q   <= '0;
      fna_q    <= '0;
      units_q  <= '0;
      epos_q   <= '0;
      pend_q   <= 2'd0;
      seqlen_q <= 3'd0;
      acc_q    <= '0;
      eval_q   <= '0;
      nas_q    <= 1'b0;
      bom_q    <= 1'b0;
      err_q    <= ERR_NONE;
    end else if (fire_i) begin
      pos_q    <= pos_d;
      lead_q   <= lead_d;
      fna_q    <= fna_d;
      units_q  <= units_d;
      epos_q   <= epos_d;
      pend_q   <= pend_d;
      seqlen_q <= seqlen_d;
      acc_q    <= acc_d;
      eval_q   <= eval_d;
      nas_q    <= nas_d;
      bom_q    <= bom_d;
      err_q    <= err_d;
    end
  end

endmodule

// ===== sv/u8u16_serial.sv =====
// Output register: holds the result bundle of one transaction and sends its records in order.
// Depends on u8u16_pkg and u8u16_out_if.
module u8u16_serial (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  u8u16_pkg::bundle_t bundle_i,
  output logic               ready_o,
  u8u16_out_if.source        out
);
  import u8u16_pkg::*;

  bundle_t    bundle_q;
  logic       full_q;
  logic [1:0] idx_q;
  logic [2:0] total;
  logic       last;
  logic       take;
  logic       is_unit;

  assign total   = {1'b0, bundle_q.n_units} + {2'b0, bundle_q.has_sum};
  assign last    = ({1'b0, idx_q} == total - 3'd1);
  assign take    = full_q && out.ready;
  assign ready_o = !full_q || (out.ready && last);
  assign is_unit = (idx_q < bundle_q.n_units);

  // record selection
  assign out.valid           = full_q;
  assign out.record_kind     = is_unit ? KIND_UNIT : KIND_SUMMARY;
  assign out.unit            = is_unit ? bundle_q.units[idx_q] : 16'd0;
  assign out.error_code      = is_unit ? ERR_NONE : bundle_q.err;
  assign out.error_offset    = is_unit ? 24'd0 : bundle_q.err_off;
  assign out.bad_value       = is_unit ? 21'd0 : bundle_q.bad;
  assign out.first_non_ascii = is_unit ? 24'd0 : bundle_q.fna;
  assign out.unit_count      = is_unit ? 24'd0 : bundle_q.cnt;
  assign out.last_of_run     = last;

  // occupancy and record index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
      idx_q  <= 2'd0;
    end else if (load_i) begin
      full_q <= 1'b1;
      idx_q  <= 2'd0;
    end else if (take) begin
      if (last) begin
        full_q <= 1'b0;
        idx_q  <= 2'd0;
      end else begin
        idx_q  <= idx_q + 2'd1;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (load_i) bundle_q <= bundle_i;
  end

endmodule

// ===== sv/utf8_to_utf16_transcoder_top.sv =====
// The first record of a transaction is valid in the cycle after it is accepted.
// Throughput: one transaction per cycle while each yields at most one record and out_o is
// ready; a transaction yielding k records (k up to 4) holds the output register until its
// last record is taken. A transaction with no record (empty item) passes with no output.
// Reset (rst_ni low, asynchronous) clears string state, config and the output register.
// Top level of the UTF-8 to UTF-16 transcoder; depends on u8u16_pkg, u8u16_if,
// u8u16_decode, u8u16_serial and utf8_to_utf16_transcoder_top_assert.svh.
`include "utf8_to_utf16_transcoder_top_assert.svh"

module utf8_to_utf16_transcoder_top #(
  parameter int unsigned POSITION_BITS = u8u16_pkg::POS_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  u8u16_in_if.sink    in_i,
  u8u16_out_if.source out_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic        cfg_wdata_i
);
  import u8u16_pkg::*;

  cfg_t    cfg_q;
  bundle_t bundle;
  logic    bundle_valid;
  logic    ready;
  logic    fire;

  assign in_i.ready = ready;
  assign fire       = in_i.valid && ready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SWAP: cfg_q.swap <= cfg_wdata_i;
        CFG_BOM:  cfg_q.bom  <= cfg_wdata_i;
        default:  cfg_q      <= cfg_q;
      endcase
    end
  end

  u8u16_decode #(
    .POSITION_BITS(POSITION_BITS)
  ) u_decode (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (fire),
    .in_byte_i      (in_i.in_byte),
    .no_byte_i      (in_i.no_byte),
    .end_of_string_i(in_i.end_of_string),
    .cfg_i          (cfg_q),
    .bundle_o       (bundle),
    .bundle_valid_o (bundle_valid)
  );

  u8u16_serial u_serial (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (fire && bundle_valid),
    .bundle_i(bundle),
    .ready_o (ready),
    .out     (out_o)
  );

  // checks
  `U8U16_ASSERT_ALWAYS(a_rst_empty, clk_i, !rst_ni |-> !out_o.valid, "output valid in reset")
  `U8U16_ASSERT(a_empty_ready, clk_i, rst_ni, !out_o.valid |-> in_i.ready, "not ready while empty")
  `U8U16_ASSERT(a_stall_blocks, clk_i, rst_ni,
                (out_o.valid && !out_o.ready) |-> !in_i.ready,
                "input taken while output stalled")
  `U8U16_ASSERT(a_sum_last, clk_i, rst_ni,
                (out_o.valid && out_o.record_kind == KIND_SUMMARY) |-> out_o.last_of_run,
                "summary not last of run")

endmodule
